[rtl/ogi_pkg.sv]
// Shared types and constants for the occupancy grid inflation block.
// No dependencies; imported by the sequencer, the top level and the testbench.
`timescale 1ns / 1ps

package ogi_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_RADIUS = 15;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DIM_W  = 9;
    localparam int RAD_W  = 4;
    localparam int LVL_W  = 7;
    localparam int CELL_W = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_CELLS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MARK_VALUE      = 3'd4;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_QUERY = 1'b1;
    localparam logic [CELL_W-1:0] CELL_UNKNOWN = 8'hFF;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CENTER,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] used_w;
        logic [DIM_W-1:0] used_h;
        logic [RAD_W-1:0] radius;
        logic [LVL_W-1:0] threshold;
        logic [LVL_W-1:0] mark;
    } t_cfg;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              re;
        logic [ADDR_W-1:0] rd_addr;
    } t_ram_req;

    typedef struct packed {
        logic [CELL_W-1:0] value;
        logic              outside;
    } t_result;

endpackage

[rtl/ogi_ram.sv]
// Simple dual-port synchronous RAM holding the raw grid cells.
// One write port, one read port with registered read data; no dependencies.
`timescale 1ns / 1ps

module ogi_ram #(
    parameter int DEPTH  = 65536,
    parameter int ADDR_W = 16,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/ogi_ctrl.sv]
// Request sequencer: stores raw cells and scans the inflation window of a query.
// Depends on ogi_pkg; drives the grid RAM and hands results to the output register.
`timescale 1ns / 1ps

module ogi_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ogi_pkg::t_cfg                   i_cfg,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_op,
    input  logic [ogi_pkg::ROW_W-1:0]       i_cell_row,
    input  logic [ogi_pkg::COL_W-1:0]       i_cell_column,
    input  logic signed [ogi_pkg::CELL_W-1:0] i_raw_value,
    output ogi_pkg::t_ram_req               o_ram_req,
    input  logic [ogi_pkg::CELL_W-1:0]      i_rd_data,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output ogi_pkg::t_result                o_res
);
    import ogi_pkg::*;

    t_state r_state, n_state;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_r0, n_r0, r_r1, n_r1;
    logic [COL_W-1:0]  r_c0, n_c0, r_c1, n_c1;
    logic              r_last, n_last;
    logic [CELL_W-1:0] r_half, n_half;
    t_result           r_res, n_res;

    logic              accept;
    logic              in_grid;
    logic [DIM_W-1:0]  row_ext, col_ext, rad_ext, row_sum, col_sum;
    logic [ROW_W-1:0]  lo_row, hi_row;
    logic [COL_W-1:0]  lo_col, hi_col;
    logic              hit;
    logic [ROW_W-1:0]  step_row;
    logic [COL_W-1:0]  step_col;

    assign accept  = i_in_valid && (r_state == S_IDLE);
    assign row_ext = DIM_W'(i_cell_row);
    assign col_ext = DIM_W'(i_cell_column);
    assign rad_ext = DIM_W'(i_cfg.radius);
    assign in_grid = (row_ext < i_cfg.used_h) && (col_ext < i_cfg.used_w);

    // Window bounds, clamped to the grid on all four sides.
    assign row_sum = row_ext + rad_ext;
    assign col_sum = col_ext + rad_ext;
    assign lo_row  = (row_ext > rad_ext) ? ROW_W'(row_ext - rad_ext) : '0;
    assign lo_col  = (col_ext > rad_ext) ? COL_W'(col_ext - rad_ext) : '0;
    assign hi_row  = (row_sum >= i_cfg.used_h) ? ROW_W'(i_cfg.used_h - DIM_W'(1))
                                               : ROW_W'(row_sum);
    assign hi_col  = (col_sum >= i_cfg.used_w) ? COL_W'(i_cfg.used_w - DIM_W'(1))
                                               : COL_W'(col_sum);

    // Negative cells are unknown and never count as obstacles.
    assign hit = $signed(i_rd_data) > $signed({1'b0, i_cfg.threshold});

    always_comb begin
        if (r_col == r_c1) begin
            step_col = r_c0;
            step_row = r_row + ROW_W'(1);
        end else begin
            step_col = r_col + COL_W'(1);
            step_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row  <= n_row;
        r_col  <= n_col;
        r_r0   <= n_r0;
        r_r1   <= n_r1;
        r_c0   <= n_c0;
        r_c1   <= n_c1;
        r_last <= n_last;
        r_half <= n_half;
        r_res  <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_col   = r_col;
        n_r0    = r_r0;
        n_r1    = r_r1;
        n_c0    = r_c0;
        n_c1    = r_c1;
        n_last  = r_last;
        n_half  = r_half;
        n_res   = r_res;
        o_in_stall          = (r_state != S_IDLE);
        o_res_valid         = 1'b0;
        o_ram_req.we        = 1'b0;
        o_ram_req.wr_addr   = {i_cell_row, i_cell_column};
        o_ram_req.wr_data   = i_raw_value;
        o_ram_req.re        = 1'b0;
        o_ram_req.rd_addr   = {i_cell_row, i_cell_column};

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_r0 = lo_row;
                    n_r1 = hi_row;
                    n_c0 = lo_col;
                    n_c1 = hi_col;
                    if (i_op == OP_WRITE) begin
                        o_ram_req.we = in_grid;
                    end else if (!in_grid) begin
                        n_res.value   = CELL_UNKNOWN;
                        n_res.outside = 1'b1;
                        n_state       = S_FINISH;
                    end else begin
                        o_ram_req.re = 1'b1;
                        n_state      = S_CENTER;
                    end
                end
            end
            S_CENTER: begin
                n_res.outside = 1'b0;
                if (i_rd_data[CELL_W-1]) begin
                    n_res.value = CELL_UNKNOWN;
                    n_state     = S_FINISH;
                end else begin
                    n_half            = {1'b0, i_rd_data[CELL_W-1:1]};
                    o_ram_req.re      = 1'b1;
                    o_ram_req.rd_addr = {r_r0, r_c0};
                    n_row             = r_r0;
                    n_col             = r_c0;
                    n_last            = (r_r0 == r_r1) && (r_c0 == r_c1);
                    n_state           = S_SCAN;
                end
            end
            S_SCAN: begin
                // The data checked here belongs to the address issued last cycle.
                if (hit) begin
                    n_res.value = {1'b0, i_cfg.mark};
                    n_state     = S_FINISH;
                end else if (r_last) begin
                    n_res.value = r_half;
                    n_state     = S_FINISH;
                end else begin
                    o_ram_req.re      = 1'b1;
                    o_ram_req.rd_addr = {step_row, step_col};
                    n_row             = step_row;
                    n_col             = step_col;
                    n_last            = (step_row == r_r1) && (step_col == r_c1);
                end
            end
            S_FINISH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

`ifndef NO_ASSERTIONS
    a_scan_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_row >= r_r0 && r_row <= r_r1 &&
                                 r_col >= r_c0 && r_col <= r_c1))
        else $error("window scan left its bounds");

    a_write_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_req.we |-> (DIM_W'(o_ram_req.wr_addr[ADDR_W-1:COL_W]) < i_cfg.used_h &&
                          DIM_W'(o_ram_req.wr_addr[COL_W-1:0]) < i_cfg.used_w))
        else $error("cell write outside the grid");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram_req.we && o_ram_req.re))
        else $error("read and write of the grid in the same cycle");

    a_outside_unknown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.outside) |-> (o_res.value == CELL_UNKNOWN))
        else $error("outside result without unknown value");

    a_center_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CENTER) |=> (r_state == S_SCAN || r_state == S_FINISH))
        else $error("center read not followed by scan or finish");
`endif

endmodule

[rtl/occupancy_grid_inflation.sv]
// Top level of the occupancy grid inflation block: configuration registers,
// output register, and the sequencer and grid RAM. Depends on ogi_pkg.
//
//   channel  handshake                    payload
//   input    i_in_valid / o_in_stall      i_op, i_cell_row, i_cell_column, i_raw_value
//   output   o_out_valid / i_out_stall    o_inflated_value, o_outside_grid
//   config   i_cfg_we                     i_cfg_index, i_cfg_data
//
// A query reads one window cell per cycle from the single read port of the grid
// RAM, ending early on the first obstacle; a query outside the grid or on an
// unknown center cell gives its result without a scan. Reset clears control
// state only; the grid is not cleared. The output register lets a result wait
// while the next request is accepted.
`timescale 1ns / 1ps

module occupancy_grid_inflation (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ogi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ogi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_op,
    input  logic [ogi_pkg::ROW_W-1:0]         i_cell_row,
    input  logic [ogi_pkg::COL_W-1:0]         i_cell_column,
    input  logic signed [ogi_pkg::CELL_W-1:0] i_raw_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [ogi_pkg::CELL_W-1:0] o_inflated_value,
    output logic                              o_outside_grid
);
    import ogi_pkg::*;

    logic [DIM_W-1:0] r_grid_width, r_grid_height;
    logic [RAD_W-1:0] r_radius;
    logic [LVL_W-1:0] r_threshold, r_mark;
    t_cfg             cfg;
    t_ram_req         ram_req;
    logic [CELL_W-1:0] rd_data;
    logic             res_valid, res_ready;
    t_result          res;
    logic             r_out_valid;
    t_result          r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= DIM_W'(MAX_WIDTH);
            r_grid_height <= DIM_W'(MAX_HEIGHT);
            r_radius      <= RAD_W'(5);
            r_threshold   <= LVL_W'(80);
            r_mark        <= LVL_W'(80);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_GRID_WIDTH:      r_grid_width  <= i_cfg_data;
                REG_GRID_HEIGHT:     r_grid_height <= i_cfg_data;
                REG_RADIUS_CELLS:    r_radius      <= i_cfg_data[RAD_W-1:0];
                REG_BLOCK_THRESHOLD: r_threshold   <= i_cfg_data[LVL_W-1:0];
                REG_MARK_VALUE:      r_mark        <= i_cfg_data[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Oversized dimensions saturate at the storage size.
    always_comb begin
        cfg.used_w    = (r_grid_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_grid_width;
        cfg.used_h    = (r_grid_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT)
                                                             : r_grid_height;
        cfg.radius    = (r_radius > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r_radius;
        cfg.threshold = r_threshold;
        cfg.mark      = r_mark;
    end

    ogi_ram #(
        .DEPTH  (MAX_WIDTH * MAX_HEIGHT),
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_req.we),
        .i_wr_addr (ram_req.wr_addr),
        .i_wr_data (ram_req.wr_data),
        .i_re      (ram_req.re),
        .i_rd_addr (ram_req.rd_addr),
        .o_rd_data (rd_data)
    );

    ogi_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (i_op),
        .i_cell_row    (i_cell_row),
        .i_cell_column (i_cell_column),
        .i_raw_value   (i_raw_value),
        .o_ram_req     (ram_req),
        .i_rd_data     (rd_data),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_inflated_value = r_out.value;
    assign o_outside_grid   = r_out.outside;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the occupancy grid inflation block: a directed plan,
// then random phases under changing grid settings. Depends on ogi_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import ogi_pkg::*;

    localparam int TOTAL_REQUESTS = 1025;
    localparam int QUIET_LIMIT    = 5000;
    localparam int SETTLE_CYCLES  = 16;

    typedef enum bit [1:0] {
        PLAN_CFG,
        PLAN_REQ,
        PLAN_TYPED
    } t_plan_kind;

    typedef struct packed {
        t_plan_kind            kind;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        logic                  op;
        logic [ROW_W-1:0]      row;
        logic [COL_W-1:0]      col;
        logic [CELL_W-1:0]     raw;
        logic [CELL_W-1:0]     want_value;
        logic                  want_outside;
    } t_plan_row;

    // Expected results are typed in only where they are obvious; the rest come
    // from the grid model below.
    localparam t_plan_row DIRECTED_PLAN [41] = '{
        '{PLAN_CFG,   REG_RADIUS_CELLS,    9'd0,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd255, 8'd255, 8'd100, 8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd255, 8'd255, 8'd0,   8'd80, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd0,   8'd0, CELL_UNKNOWN, 8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd0,   8'd0, 8'd0, CELL_UNKNOWN, 1'b0},
        '{PLAN_CFG,   REG_GRID_WIDTH,      9'd2,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_GRID_HEIGHT,     9'd2,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_RADIUS_CELLS,    9'd1,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd0,   8'd1,   8'd127, 8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd1,   8'd0,   8'h80,  8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd1,   8'd1,   8'd40,  8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd2,   8'd2,   8'd5,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_QUERY, 8'd1,   8'd1,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_QUERY, 8'd0,   8'd1,   8'd0,   8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd1,   8'd0, 8'd0, CELL_UNKNOWN, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd2,   8'd0, 8'd0, CELL_UNKNOWN, 1'b1},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd0, 8'd255, 8'd0, CELL_UNKNOWN, 1'b1},
        '{PLAN_CFG,   REG_BLOCK_THRESHOLD, 9'd127, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_MARK_VALUE,      9'd127, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_QUERY, 8'd0,   8'd1,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_QUERY, 8'd1,   8'd1,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_BLOCK_THRESHOLD, 9'd0,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_MARK_VALUE,      9'd0,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_QUERY, 8'd1,   8'd1,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_GRID_WIDTH,      9'd0,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd0,   8'd0, 8'd0, CELL_UNKNOWN, 1'b1},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd0,   8'd0,   8'd7,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_GRID_WIDTH,      9'd511, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_GRID_HEIGHT,     9'd2,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_RADIUS_CELLS,    9'd0,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_BLOCK_THRESHOLD, 9'd100, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_MARK_VALUE,      9'd100, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd1,   8'd255, 8'd50,  8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd1,   8'd255, 8'd0,  8'd25, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd2, 8'd255, 8'd0, CELL_UNKNOWN, 1'b1},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd0,   8'd0,   8'd101, 8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd0,   8'd0,   8'd0, 8'd100, 1'b0},
        '{PLAN_CFG,   REG_GRID_WIDTH,      9'd1,   OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_CFG,   REG_GRID_HEIGHT,     9'd511, OP_WRITE, 8'd0,   8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_REQ,   '0,                  '0,     OP_WRITE, 8'd255, 8'd0,   8'd0,   8'd0, 1'b0},
        '{PLAN_TYPED, '0,                  '0,     OP_QUERY, 8'd255, 8'd0,   8'd0,   8'd0, 1'b0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic                    i_op = OP_WRITE;
    logic [ROW_W-1:0]        i_cell_row = '0;
    logic [COL_W-1:0]        i_cell_column = '0;
    logic [CELL_W-1:0]       i_raw_value = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic signed [CELL_W-1:0] o_inflated_value;
    logic                    o_outside_grid;

    // Model of the grid: raw cells, which of them were ever written, and settings.
    logic signed [CELL_W-1:0] occ_cells [MAX_WIDTH*MAX_HEIGHT];
    bit                       cell_written [MAX_WIDTH*MAX_HEIGHT];
    int cur_width = 256;
    int cur_height = 256;
    int cur_radius = 5;
    int cur_threshold = 80;
    int cur_mark = 80;

    t_result inflated_q [$];
    int      mismatches = 0;
    int      quiet_cycles = 0;
    int      stall_left = 0;
    bit      gaps_on = 1'b1;
    bit      need_settle = 1'b0;

    occupancy_grid_inflation dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_op             (i_op),
        .i_cell_row       (i_cell_row),
        .i_cell_column    (i_cell_column),
        .i_raw_value      (i_raw_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_inflated_value (o_inflated_value),
        .o_outside_grid   (o_outside_grid)
    );

    always #6 i_clk = ~i_clk;

    function automatic int used_dim(int value, int limit);
        return value > limit ? limit : value;
    endfunction

    function automatic bit cell_inside(int row, int col);
        return row < used_dim(cur_height, MAX_HEIGHT) && col < used_dim(cur_width, MAX_WIDTH);
    endfunction

    // Square window around a cell, inclusive and clamped to the grid in use.
    function automatic void window_of(input int row, col, output int r0, r1, c0, c1);
        int h, w, rad;
        h = used_dim(cur_height, MAX_HEIGHT);
        w = used_dim(cur_width, MAX_WIDTH);
        rad = used_dim(cur_radius, MAX_RADIUS);
        r0 = row > rad ? row - rad : 0;
        r1 = row + rad >= h ? h - 1 : row + rad;
        c0 = col > rad ? col - rad : 0;
        c1 = col + rad >= w ? w - 1 : col + rad;
    endfunction

    function automatic bit find_unwritten(input int row, col, output int miss_row, miss_col);
        int r0, r1, c0, c1;
        window_of(row, col, r0, r1, c0, c1);
        miss_row = 0;
        miss_col = 0;
        for (int r = r0; r <= r1; r++) begin
            for (int c = c0; c <= c1; c++) begin
                if (!cell_written[r * MAX_WIDTH + c]) begin
                    miss_row = r;
                    miss_col = c;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic void inflate_cell(input logic op, input int row, col,
                                         input logic [CELL_W-1:0] raw,
                                         output bit produces, output t_result res);
        int r0, r1, c0, c1, center;
        bit hit;
        produces = (op == OP_QUERY);
        res = '0;
        if (op == OP_WRITE) begin
            if (cell_inside(row, col)) begin
                occ_cells[row * MAX_WIDTH + col] = raw;
                cell_written[row * MAX_WIDTH + col] = 1'b1;
            end
        end else if (!cell_inside(row, col)) begin
            res.value = CELL_UNKNOWN;
            res.outside = 1'b1;
        end else begin
            center = occ_cells[row * MAX_WIDTH + col];
            if (center < 0) begin
                res.value = CELL_UNKNOWN;
            end else begin
                window_of(row, col, r0, r1, c0, c1);
                hit = 1'b0;
                for (int r = r0; r <= r1; r++)
                    for (int c = c0; c <= c1; c++)
                        if (occ_cells[r * MAX_WIDTH + c] > cur_threshold)
                            hit = 1'b1;
                res.value = hit ? CELL_W'(cur_mark) : CELL_W'(center / 2);
            end
        end
    endfunction

    function automatic logic [CELL_W-1:0] rand_occupancy();
        case ($urandom_range(0, 9))
            0: return CELL_UNKNOWN;
            // Other negative codes must read as unknown too.
            1: return CELL_W'($urandom_range(128, 254));
            2: return CELL_W'($urandom_range(101, 127));
            3: return 8'd100;
            4: return 8'd0;
            default: return CELL_W'($urandom_range(0, 100));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 9'd256;
            2: return CFG_DATA_W'($urandom_range(257, 511));
            3: return CFG_DATA_W'($urandom_range(17, 255));
            default: return CFG_DATA_W'($urandom_range(1, 16));
        endcase
    endfunction

    // Most cells land in the corner near the origin so that windows fill up quickly.
    task automatic pick_cell(output int row, col);
        int h, w;
        h = used_dim(cur_height, MAX_HEIGHT);
        w = used_dim(cur_width, MAX_WIDTH);
        case ($urandom_range(0, 9))
            0, 1: begin
                row = $urandom_range(0, MAX_HEIGHT - 1);
                col = $urandom_range(0, MAX_WIDTH - 1);
            end
            2: begin
                row = $urandom_range(MAX_HEIGHT - 16, MAX_HEIGHT - 1);
                col = $urandom_range(MAX_WIDTH - 16, MAX_WIDTH - 1);
            end
            default: begin
                row = $urandom_range(0, (h == 0 || h > 16) ? 15 : h - 1);
                col = $urandom_range(0, (w == 0 || w > 16) ? 15 : w - 1);
            end
        endcase
    endtask

    task automatic wait_drained();
        if (need_settle) begin
            i_in_valid <= 1'b0;
            while (inflated_q.size() != 0)
                @(posedge i_clk);
            // A write gives no result, so the last one may still be in flight.
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            need_settle = 1'b0;
        end
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (index)
            REG_GRID_WIDTH:      cur_width = data;
            REG_GRID_HEIGHT:     cur_height = data;
            REG_RADIUS_CELLS:    cur_radius = data[RAD_W-1:0];
            REG_BLOCK_THRESHOLD: cur_threshold = data[LVL_W-1:0];
            REG_MARK_VALUE:      cur_mark = data[LVL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic issue(input logic op, input int row, col, input logic [CELL_W-1:0] raw,
                         input bit typed, input t_result typed_res);
        bit produces;
        t_result res;
        inflate_cell(op, row, col, raw, produces, res);
        if (produces) begin
            if (typed)
                res = typed_res;
            inflated_q = {inflated_q, res};
        end
        i_cfg_we <= 1'b0;
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_cell_row <= ROW_W'(row);
        i_cell_column <= COL_W'(col);
        i_raw_value <= raw;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0)
            @(posedge i_clk);
        need_settle = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (inflated_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: value %0d outside %0b",
                             o_inflated_value, o_outside_grid);
            end else begin
                want = inflated_q.pop_front();
                if (o_inflated_value !== want.value || o_outside_grid !== want.outside) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %0d outside %0b, got %0d outside %0b",
                                 $signed(want.value), want.outside,
                                 o_inflated_value, o_outside_grid);
                end
            end
        end
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_plan_row step;
        int row, col, miss_row, miss_col, done, phase_len, thr, mark;
        logic [CFG_DATA_W-1:0] junk;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < $size(DIRECTED_PLAN); i++) begin
            step = DIRECTED_PLAN[i];
            if (step.kind == PLAN_CFG)
                cfg_write(step.cfg_index, step.cfg_data);
            else
                issue(step.op, step.row, step.col, step.raw, step.kind == PLAN_TYPED,
                      {step.want_value, step.want_outside});
        end

        done = 0;
        while (done < TOTAL_REQUESTS) begin
            gaps_on = done < TOTAL_REQUESTS - 100 && $urandom_range(0, 3) != 0;
            // Narrow registers sometimes get junk in the unused upper bits.
            junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom) : '0;
            case ($urandom_range(0, 5))
                0: thr = 0;
                1: thr = 127;
                2: thr = 100;
                default: thr = $urandom_range(40, 127);
            endcase
            case ($urandom_range(0, 4))
                0: mark = 0;
                1: mark = 127;
                default: mark = $urandom_range(0, 100);
            endcase
            cfg_write(REG_GRID_WIDTH, pick_dim());
            cfg_write(REG_GRID_HEIGHT, pick_dim());
            cfg_write(REG_RADIUS_CELLS, {junk[8:4], 4'($urandom_range(0, 15))});
            cfg_write(REG_BLOCK_THRESHOLD, {junk[8:7], 7'(thr)});
            cfg_write(REG_MARK_VALUE, {junk[8:7], 7'(mark)});

            phase_len = $urandom_range(30, 120);
            for (int k = 0; k < phase_len && done < TOTAL_REQUESTS; k++) begin
                if (done >= TOTAL_REQUESTS - 100)
                    gaps_on = 1'b0;
                pick_cell(row, col);
                if ($urandom_range(0, 99) >= 55)
                    issue(OP_WRITE, row, col, rand_occupancy(), 1'b0, '0);
                else if (cell_inside(row, col) && find_unwritten(row, col, miss_row, miss_col))
                    // A query may only see written cells, so its window is filled first.
                    issue(OP_WRITE, miss_row, miss_col, rand_occupancy(), 1'b0, '0);
                else
                    issue(OP_QUERY, row, col, CELL_W'($urandom), 1'b0, '0);
                done++;
            end
        end

        gaps_on = 1'b0;
        wait_drained();
        if (mismatches == 0 && inflated_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
